FILE: src/psgr_pkg.sv
`default_nettype none

package psgr_pkg;

  localparam int NODE_W        = 6;
  localparam int MASK_W        = 64;
  localparam int OPCODE_W      = 3;
  localparam int DEFAULT_NODES = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TEST   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_PATH   = 3'd3,
    OP_SET    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_Q_RD,
    ST_Q_EX,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/psgr_in_if.sv
`default_nettype none

interface psgr_in_if;
  logic                            valid;
  logic                            ready;
  logic [psgr_pkg::OPCODE_W-1:0]   opcode;
  logic [psgr_pkg::NODE_W-1:0]     from_node;
  logic [psgr_pkg::NODE_W-1:0]     to_node;
  logic [psgr_pkg::MASK_W-1:0]     parent_mask;

  modport source (output valid, output opcode, output from_node, output to_node,
                  output parent_mask, input ready);
  modport sink (input valid, input opcode, input from_node, input to_node,
                input parent_mask, output ready);
endinterface

`default_nettype wire

FILE: src/psgr_out_if.sv
`default_nettype none

interface psgr_out_if;
  logic valid;
  logic ready;
  logic answer;

  modport source (output valid, output answer, input ready);
  modport sink (input valid, input answer, output ready);
endinterface

`default_nettype wire

FILE: src/parent_set_graph_reachability_core.sv
`default_nettype none

// Directed graph store of up to NODES nodes, one parent row per node, empty after
// reset. Each input beat tests, adds or removes an edge, replaces a node's parent
// set, or asks whether from_node is an ancestor of to_node, and yields one output
// beat. An edge operation reads its row in ST_IDLE, tests or rewrites it in ST_EDGE
// and loads the result register in ST_DONE; a parent set write goes straight to
// ST_DONE. A path query expands one parent row per ST_Q_RD/ST_Q_EX pair, as each
// row comes through the single registered read port of the parent row memory. A new
// beat is accepted while the previous result still waits in the output register.
module parent_set_graph_reachability_core #(
  parameter int NODES = psgr_pkg::DEFAULT_NODES
) (
  input  wire        clk,
  input  wire        rst_n,
  psgr_in_if.sink    in_ch,
  psgr_out_if.source out_ch
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [psgr_pkg::NODE_W:0] NODES_C = (psgr_pkg::NODE_W + 1)'(NODES);

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_vld_r;
  logic [NODES-1:0] rd_data_r;
  logic             rd_vld_r;

  psgr_pkg::state_t state_r, state_nxt;
  logic [psgr_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [IDX_W-1:0] from_r, from_nxt;
  logic [IDX_W-1:0] to_r, to_nxt;
  logic [NODES-1:0] vis_r, vis_nxt;
  logic [NODES-1:0] pend_r, pend_nxt;
  logic             ans_r, ans_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_answer_r, out_answer_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [NODES-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic [NODES-1:0] row_q;
  logic [NODES-1:0] low_bit;
  logic [IDX_W-1:0] low_idx;
  logic [NODES-1:0] new_nodes;
  logic [NODES-1:0] from_bit;
  logic             in_from_ok;
  logic             in_to_ok;
  logic [IDX_W-1:0] in_from_idx;
  logic [IDX_W-1:0] in_to_idx;

  function automatic logic [NODES-1:0] onehot(input logic [IDX_W-1:0] idx);
    onehot = {{(NODES-1){1'b0}}, 1'b1} << idx;
  endfunction

  assign in_from_ok  = {1'b0, in_ch.from_node} < NODES_C;
  assign in_to_ok    = {1'b0, in_ch.to_node} < NODES_C;
  assign in_from_idx = in_ch.from_node[IDX_W-1:0];
  assign in_to_idx   = in_ch.to_node[IDX_W-1:0];

  assign row_q     = rd_vld_r ? rd_data_r : '0;
  assign from_bit  = onehot(from_r);
  assign new_nodes = row_q & ~vis_r;
  assign low_bit   = pend_r & (~pend_r + NODES'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NODES; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    vis_nxt        = vis_r;
    pend_nxt       = pend_r;
    ans_nxt        = ans_r;
    out_valid_nxt  = out_valid_r;
    out_answer_nxt = out_answer_r;
    wr_en          = 1'b0;
    wr_addr        = to_r;
    wr_data        = row_q;
    rd_en          = 1'b0;
    rd_addr        = to_r;
    in_ch.ready    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      psgr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          from_nxt  = in_from_idx;
          to_nxt    = in_to_idx;
          ans_nxt   = 1'b0;
          state_nxt = psgr_pkg::ST_DONE;
          case (in_ch.opcode) inside
            psgr_pkg::OP_TEST, psgr_pkg::OP_ADD, psgr_pkg::OP_REMOVE: begin
              if (in_from_ok && in_to_ok) begin
                rd_en     = 1'b1;
                rd_addr   = in_to_idx;
                state_nxt = psgr_pkg::ST_EDGE;
              end
            end
            psgr_pkg::OP_SET: begin
              if (in_to_ok) begin
                wr_en   = 1'b1;
                wr_addr = in_to_idx;
                wr_data = in_ch.parent_mask[NODES-1:0];
              end
            end
            psgr_pkg::OP_PATH: begin
              if (in_from_ok && in_to_ok) begin
                if (in_ch.from_node == in_ch.to_node) begin
                  ans_nxt = 1'b1;
                end else begin
                  vis_nxt   = onehot(in_to_idx);
                  pend_nxt  = onehot(in_to_idx);
                  state_nxt = psgr_pkg::ST_Q_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      psgr_pkg::ST_EDGE: begin
        state_nxt = psgr_pkg::ST_DONE;
        case (op_r)
          psgr_pkg::OP_TEST: ans_nxt = row_q[from_r];
          psgr_pkg::OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = row_q | from_bit;
          end
          default: begin
            wr_en   = 1'b1;
            wr_data = row_q & ~from_bit;
          end
        endcase
      end
      psgr_pkg::ST_Q_RD: begin
        if (pend_r == '0) begin
          ans_nxt   = 1'b0;
          state_nxt = psgr_pkg::ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = low_idx;
          pend_nxt  = pend_r & ~low_bit;
          state_nxt = psgr_pkg::ST_Q_EX;
        end
      end
      psgr_pkg::ST_Q_EX: begin
        if (new_nodes[from_r]) begin
          ans_nxt   = 1'b1;
          state_nxt = psgr_pkg::ST_DONE;
        end else begin
          vis_nxt   = vis_r | new_nodes;
          pend_nxt  = pend_r | new_nodes;
          state_nxt = psgr_pkg::ST_Q_RD;
        end
      end
      psgr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_answer_nxt = ans_r;
          state_nxt      = psgr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psgr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psgr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    vis_r        <= vis_nxt;
    pend_r       <= pend_nxt;
    ans_r        <= ans_nxt;
    out_answer_r <= out_answer_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = out_answer_r;

  a_dst_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psgr_pkg::ST_Q_RD || state_r == psgr_pkg::ST_Q_EX) |-> vis_r[to_r])
    else $error("query destination missing from visited set");

  a_pend_in_vis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psgr_pkg::ST_Q_RD || state_r == psgr_pkg::ST_Q_EX)
      |-> ((pend_r & ~vis_r) == '0))
    else $error("pending node not marked visited");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == psgr_pkg::ST_DONE))
    else $error("result beat raised outside completion");

endmodule

`default_nettype wire

FILE: tb/psgr_answer_check.sv
module psgr_answer_check #(
  parameter int NODES = psgr_pkg::DEFAULT_NODES
) (
  input  logic clk,
  input  logic rst_n,
  psgr_in_if   in_ch,
  psgr_out_if  out_ch,
  output int   mismatches,
  output int   outstanding,
  output int   compared,
  output int   reached
);
  import psgr_pkg::*;

  localparam logic [MASK_W-1:0] LIVE_NODES = {MASK_W{1'b1}} >> (MASK_W - NODES);

  logic [MASK_W-1:0] parent_row [64];
  logic [MASK_W-1:0] seen_set;
  logic [MASK_W-1:0] wave_set;
  logic              answer_due [$];

  // Breadth-first walk up the parent rows, starting at the destination.
  function automatic logic ancestor_of(int src, int dst);
    logic [MASK_W-1:0] grown;
    if (src == dst) return 1'b1;
    seen_set = '0;
    seen_set[dst] = 1'b1;
    wave_set = parent_row[dst] & LIVE_NODES & ~seen_set;
    for (int r = 0; r < NODES; r++) begin
      if (wave_set[src]) return 1'b1;
      if (wave_set == '0) return 1'b0;
      seen_set |= wave_set;
      grown = '0;
      for (int i = 0; i < NODES; i++) begin
        if (wave_set[i]) grown |= parent_row[i];
      end
      wave_set = grown & LIVE_NODES & ~seen_set;
    end
    return wave_set[src];
  endfunction

  function automatic logic apply_request(logic [OPCODE_W-1:0] op, int src, int dst,
                                         logic [MASK_W-1:0] mask);
    logic ends_ok;
    ends_ok = (src < NODES) && (dst < NODES);
    case (op)
      OP_TEST: begin
        return ends_ok && parent_row[dst][src];
      end
      OP_ADD: begin
        if (ends_ok) parent_row[dst][src] = 1'b1;
      end
      OP_REMOVE: begin
        if (ends_ok) parent_row[dst][src] = 1'b0;
      end
      OP_PATH: begin
        return ends_ok && ancestor_of(src, dst);
      end
      OP_SET: begin
        if (dst < NODES) parent_row[dst] = mask & LIVE_NODES;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic want;
    logic got;
    if (!rst_n) begin
      foreach (parent_row[i]) parent_row[i] = '0;
      seen_set = '0;
      wave_set = '0;
      answer_due.delete();
      mismatches  <= 0;
      outstanding <= 0;
      compared    <= 0;
      reached     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_due.size() == 0) begin
          $display("%0t: answer beat %b arrived with no request waiting", $time,
                   out_ch.answer);
          mismatches <= mismatches + 1;
        end else begin
          want = answer_due.pop_front();
          compared <= compared + 1;
          if (out_ch.answer !== want) begin
            $display("%0t: answer mismatch, expected %b, actual %b", $time, want,
                     out_ch.answer);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got = apply_request(in_ch.opcode, int'(in_ch.from_node), int'(in_ch.to_node),
                            in_ch.parent_mask);
        if (in_ch.opcode == OP_PATH && got) reached <= reached + 1;
        answer_due.insert(answer_due.size(), got);
      end
      outstanding <= answer_due.size();
    end
  end

endmodule

FILE: tb/tb_parent_set_graph_reachability_core.sv
module tb_parent_set_graph_reachability_core;
  import psgr_pkg::*;

  localparam int NODES       = DEFAULT_NODES;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 2 * NODES + 10;

  localparam logic [OPCODE_W-1:0] OP_SPARE_A = OPCODE_W'(int'(OP_SET) + 1);
  localparam logic [OPCODE_W-1:0] OP_SPARE_B = OPCODE_W'(int'(OP_SET) + 2);
  localparam logic [OPCODE_W-1:0] OP_SPARE_C = OPCODE_W'(int'(OP_SET) + 3);

  logic clk;
  logic rst_n;
  int   cycle_cnt = 0;
  int   hold_cnt = 0;
  int   sink_gap_pct = 0;
  int   src_gap_pct = 0;
  int   win_base = 0;
  int   win_size = NODES;
  int   op_count [8];
  int   mismatches;
  int   outstanding;
  int   compared;
  int   reached;

  psgr_in_if  in_ch ();
  psgr_out_if out_ch ();

  parent_set_graph_reachability_core #(.NODES(NODES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  psgr_answer_check #(.NODES(NODES)) u_answer_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared),
    .reached     (reached)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("parent_set_graph_reachability_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gap_pct != 0 && $urandom_range(99) < sink_gap_pct) begin
      hold_cnt <= $urandom_range(14, 0);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic issue(input logic [OPCODE_W-1:0] op, input logic [NODE_W-1:0] src,
                       input logic [NODE_W-1:0] dst, input logic [MASK_W-1:0] mask);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.from_node   <= src;
    in_ch.to_node     <= dst;
    in_ch.parent_mask <= mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    op_count[op]++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [OPCODE_W-1:0] op;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [MASK_W-1:0]   m;
    logic [MASK_W-1:0]   wmask;
    if ($urandom_range(14) == 0) begin
      r = $urandom_range(9);
      win_size = (r < 4) ? 6 : (r < 7) ? 12 : (r < 9) ? 24 : NODES;
      win_base = $urandom_range(NODES - win_size);
    end
    wmask = ({MASK_W{1'b1}} >> (MASK_W - win_size)) << win_base;
    a = NODE_W'(win_base + $urandom_range(win_size - 1));
    b = NODE_W'(win_base + $urandom_range(win_size - 1));
    r = $urandom_range(9);
    if (r == 0) m = '0;
    else if (r < 3) m = {$urandom, $urandom};
    else m = {$urandom, $urandom} & {$urandom, $urandom} & wmask;
    r = $urandom_range(99);
    if (r < 18) op = OP_TEST;
    else if (r < 40) op = OP_ADD;
    else if (r < 50) op = OP_REMOVE;
    else if (r < 80) op = OP_PATH;
    else if (r < 95) op = OP_SET;
    else op = OPCODE_W'($urandom_range(int'(OP_SPARE_C), int'(OP_SPARE_A)));
    issue(op, a, b, m);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    in_ch.parent_mask = '0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    issue(OP_TEST, 6'd0, 6'd0, '0);
    issue(OP_PATH, 6'd5, 6'd5, '0);
    issue(OP_PATH, 6'd0, 6'd63, '0);
    issue(OP_ADD, 6'd0, 6'd0, '0);
    issue(OP_TEST, 6'd0, 6'd0, '0);
    issue(OP_ADD, 6'd0, 6'd10, '0);
    issue(OP_ADD, 6'd10, 6'd20, '0);
    issue(OP_ADD, 6'd20, 6'd63, '0);
    issue(OP_PATH, 6'd0, 6'd63, '0);
    issue(OP_PATH, 6'd63, 6'd0, '0);
    issue(OP_SET, 6'd0, 6'd63, {MASK_W{1'b1}});
    issue(OP_TEST, 6'd5, 6'd63, '0);
    issue(OP_SET, 6'd63, 6'd63, '0);
    issue(OP_TEST, 6'd20, 6'd63, '0);
    issue(OP_PATH, 6'd0, 6'd63, '0);
    issue(OP_REMOVE, 6'd0, 6'd0, '0);
    issue(OP_TEST, 6'd0, 6'd0, '0);
    issue(OP_SET, 6'd0, 6'd1, {(MASK_W / 2){2'b10}});
    issue(OP_SET, 6'd63, 6'd2, {(MASK_W / 2){2'b01}});
    issue(OP_TEST, 6'd63, 6'd1, '0);
    issue(OP_TEST, 6'd62, 6'd2, '0);
    issue(OP_SPARE_A, 6'd63, 6'd63, {MASK_W{1'b1}});
    issue(OP_SPARE_B, 6'd0, 6'd63, {MASK_W{1'b1}});
    issue(OP_SPARE_C, 6'd63, 6'd0, {MASK_W{1'b1}});
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 5) begin
        src_gap_pct = 0;
        sink_gap_pct <= 0;
      end else begin
        src_gap_pct = (seg % 3 == 0) ? 0 : $urandom_range(30, 5);
        sink_gap_pct <= (seg % 3 == 1) ? 0 : $urandom_range(30, 5);
      end
      repeat (90) random_item();
      if (seg == 2) drain();
      if (seg == 3) begin
        // A single chain through every node gives the longest possible walk.
        issue(OP_SET, NODE_W'($urandom), 6'd0, '0);
        for (int i = 1; i < NODES; i++) begin
          issue(OP_SET, NODE_W'($urandom), NODE_W'(i), MASK_W'(1) << (i - 1));
        end
        issue(OP_PATH, 6'd0, 6'd63, '0);
        issue(OP_PATH, 6'd63, 6'd0, '0);
        issue(OP_PATH, 6'd1, 6'd63, '0);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d tests, %0d adds, %0d removes, %0d path queries, %0d parent sets,",
             op_count[OP_TEST], op_count[OP_ADD], op_count[OP_REMOVE],
             op_count[OP_PATH], op_count[OP_SET]);
    $display("%0d unknown opcodes; %0d answers compared, %0d queries found a path.",
             op_count[OP_SPARE_A] + op_count[OP_SPARE_B] + op_count[OP_SPARE_C],
             compared, reached);
    if (mismatches == 0) begin
      $display("parent_set_graph_reachability_core test passed");
    end else begin
      $display("parent_set_graph_reachability_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/psgr_pkg.sv
src/psgr_in_if.sv
src/psgr_out_if.sv
src/parent_set_graph_reachability_core.sv
tb/psgr_answer_check.sv
tb/tb_parent_set_graph_reachability_core.sv
